[design/amd_pkg.sv]
`default_nettype none

package amd_pkg;

   // Default sizes of the matrix store.
   localparam int MAX_SPEAKERS_DEF = 16;
   localparam int MAX_ORDER_DEF    = 7;

   // A decode never emits more than this many results.
   localparam int RESULT_LIMIT = 16;

   // Field widths.
   localparam int OPCODE_W    = 2;
   localparam int SPEAKER_W   = 4;
   localparam int COMPONENT_W = 4;
   localparam int COEF_W      = 18;
   localparam int SAMPLE_W    = 24;
   localparam int FRAC_BITS   = 17;
   localparam int PROD_W      = COEF_W + SAMPLE_W;
   // At most fifteen products are summed, so four guard bits are enough.
   localparam int ACC_W       = PROD_W + 4;

   localparam int COUNT_W     = 5;
   localparam int ORDER_W     = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   // Opcodes.
   localparam logic [OPCODE_W-1:0] OP_WRITE_COEF = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RECORD     = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PROCESS    = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_SPEAKER_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DECODE_ORDER  = 2'd1;

   localparam logic [COUNT_W-1:0] SPEAKER_COUNT_RST = 5'd4;
   localparam logic [ORDER_W-1:0] DECODE_ORDER_RST  = 3'd1;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   // Microcode addresses.
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_CLEAR = 3'd0;
   localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_ISSUE = 3'd2;
   localparam logic [STEP_W-1:0] STEP_WAIT1 = 3'd3;
   localparam logic [STEP_W-1:0] STEP_WAIT2 = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd5;

   typedef enum logic [2:0] {
      BR_ALWAYS,
      BR_CLEAR_DONE,
      BR_DECODE,
      BR_COMP_DONE,
      BR_SPK_LAST
   } branch_type;

   typedef struct packed {
      logic              wait_slot;
      branch_type        br_sel;
      logic [STEP_W-1:0] target_t;
      logic [STEP_W-1:0] target_f;
      logic              ready;
      logic              clear;
      logic              issue;
      logic              emit;
   } amd_uop_type;

   typedef struct packed {
      logic ready;
      logic clear;
      logic issue;
      logic emit;
   } amd_ctrl_type;

   typedef struct packed {
      logic clear_done;
      logic decode_go;
      logic comp_last;
      logic spk_last;
      logic slot_free;
   } amd_status_type;

   // Control store. Each word names a wait, a branch test and both targets.
   function automatic amd_uop_type amd_rom(input logic [STEP_W-1:0] step);
      amd_uop_type uop;
      uop.wait_slot = 1'b0;
      uop.br_sel    = BR_ALWAYS;
      uop.target_t  = STEP_IDLE;
      uop.target_f  = STEP_IDLE;
      uop.ready     = 1'b0;
      uop.clear     = 1'b0;
      uop.issue     = 1'b0;
      uop.emit      = 1'b0;
      case (step)
         STEP_CLEAR: begin
            uop.br_sel   = BR_CLEAR_DONE;
            uop.target_t = STEP_IDLE;
            uop.target_f = STEP_CLEAR;
            uop.clear    = 1'b1;
         end
         STEP_IDLE: begin
            uop.br_sel   = BR_DECODE;
            uop.target_t = STEP_ISSUE;
            uop.target_f = STEP_IDLE;
            uop.ready    = 1'b1;
         end
         STEP_ISSUE: begin
            uop.br_sel   = BR_COMP_DONE;
            uop.target_t = STEP_WAIT1;
            uop.target_f = STEP_ISSUE;
            uop.issue    = 1'b1;
         end
         STEP_WAIT1: begin
            uop.target_t = STEP_WAIT2;
         end
         STEP_WAIT2: begin
            uop.target_t = STEP_EMIT;
         end
         STEP_EMIT: begin
            uop.wait_slot = 1'b1;
            uop.br_sel    = BR_SPK_LAST;
            uop.target_t  = STEP_IDLE;
            uop.target_f  = STEP_ISSUE;
            uop.emit      = 1'b1;
         end
         default: begin
            uop.target_t = STEP_IDLE;
         end
      endcase
      return uop;
   endfunction

endpackage

`default_nettype wire

[design/amd_req_if.sv]
`default_nettype none

interface amd_req_if;
   logic                                      valid;
   logic                                      ready;
   logic        [amd_pkg::OPCODE_W-1:0]       opcode;
   logic        [amd_pkg::SPEAKER_W-1:0]      speaker;
   logic        [amd_pkg::COMPONENT_W-1:0]    component;
   logic signed [amd_pkg::COEF_W-1:0]         coefficient;
   logic signed [amd_pkg::SAMPLE_W-1:0]       harmonic_value;

   modport source (output valid, output opcode, output speaker, output component,
                   output coefficient, output harmonic_value, input ready);
   modport sink (input valid, input opcode, input speaker, input component,
                 input coefficient, input harmonic_value, output ready);
endinterface

`default_nettype wire

[design/amd_rsp_if.sv]
`default_nettype none

interface amd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [amd_pkg::SPEAKER_W-1:0] speaker_index;
   logic signed [amd_pkg::SAMPLE_W-1:0]  speaker_sample;
   logic                                last;

   modport source (output valid, output speaker_index, output speaker_sample,
                   output last, input ready);
   modport sink (input valid, input speaker_index, input speaker_sample,
                 input last, output ready);
endinterface

`default_nettype wire

[design/amd_csr_if.sv]
`default_nettype none

interface amd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [amd_pkg::CSR_INDEX_W-1:0]     index;
   logic [amd_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/amd_ram.sv]
`default_nettype none

module amd_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 240,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/amd_sequencer.sv]
`default_nettype none

module amd_sequencer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire amd_pkg::amd_status_type status,
   output amd_pkg::amd_ctrl_type        ctrl
);

   logic [amd_pkg::STEP_W-1:0] pc_ff;
   logic [amd_pkg::STEP_W-1:0] pc_in;
   amd_pkg::amd_uop_type       uop;
   logic                       taken;

   assign uop = amd_pkg::amd_rom(pc_ff);

   always_comb begin
      case (uop.br_sel)
         amd_pkg::BR_ALWAYS:     taken = 1'b1;
         amd_pkg::BR_CLEAR_DONE: taken = status.clear_done;
         amd_pkg::BR_DECODE:     taken = status.decode_go;
         amd_pkg::BR_COMP_DONE:  taken = status.comp_last;
         amd_pkg::BR_SPK_LAST:   taken = status.spk_last;
         default:                taken = 1'b1;
      endcase
   end

   always_comb begin
      if (uop.wait_slot && !status.slot_free) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = uop.target_t;
      end else begin
         pc_in = uop.target_f;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= amd_pkg::STEP_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.ready = uop.ready;
   assign ctrl.clear = uop.clear;
   assign ctrl.issue = uop.issue;
   assign ctrl.emit  = uop.emit;

endmodule

`default_nettype wire

[design/amd_datapath.sv]
`default_nettype none

module amd_datapath #(
   parameter int MAX_SPEAKERS = amd_pkg::MAX_SPEAKERS_DEF,
   parameter int MAX_ORDER    = amd_pkg::MAX_ORDER_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire amd_pkg::amd_ctrl_type ctrl,
   output amd_pkg::amd_status_type    status,
   amd_req_if.sink                    req_ch,
   amd_rsp_if.source                  rsp_ch,
   amd_csr_if.sink                    csr_ch
);

   localparam int COMPONENTS  = 2 * MAX_ORDER + 1;
   localparam int CDEPTH      = MAX_SPEAKERS * COMPONENTS;
   localparam int CADDR_W     = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
   localparam int HADDR_W     = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
   localparam int COUNT_LIMIT = (MAX_SPEAKERS < amd_pkg::RESULT_LIMIT) ?
                                MAX_SPEAKERS : amd_pkg::RESULT_LIMIT;
   localparam int SAT_LSB     = amd_pkg::FRAC_BITS + amd_pkg::SAMPLE_W - 1;

   // Configuration registers.
   logic [amd_pkg::COUNT_W-1:0] spk_count_ff, spk_count_in;
   logic [amd_pkg::ORDER_W-1:0] order_ff, order_in;

   // Sequencing counters.
   logic [CADDR_W-1:0]              clr_cnt_ff, clr_cnt_in;
   logic [amd_pkg::SPEAKER_W-1:0]   spk_ff, spk_in;
   logic [amd_pkg::COMPONENT_W-1:0] comp_ff, comp_in;

   // Multiply-accumulate pipeline.
   logic                              data_v_ff, data_v_in;
   logic                              prod_v_ff, prod_v_in;
   logic signed [amd_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [amd_pkg::ACC_W-1:0]  acc_ff, acc_in;

   // Output register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [amd_pkg::SPEAKER_W-1:0]       rsp_index_ff, rsp_index_in;
   logic signed [amd_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic [amd_pkg::COUNT_W-1:0]         eff_count;
   logic [amd_pkg::ORDER_W-1:0]         eff_order;
   logic [amd_pkg::COMPONENT_W-1:0]     comp_end;
   logic                                req_fire;
   logic                                decode_go;
   logic                                emit_fire;
   logic                                slot_free;
   logic                                spk_last;
   logic                                wr_coef_ok;
   logic                                wr_harm_ok;
   logic signed [amd_pkg::SAMPLE_W-1:0] sample;
   logic [amd_pkg::ACC_W-1-SAT_LSB:0]   sat_bits;

   logic                          coef_we;
   logic [CADDR_W-1:0]            coef_waddr, coef_raddr;
   logic [amd_pkg::COEF_W-1:0]    coef_wdata, coef_rd;
   logic                          harm_we;
   logic [HADDR_W-1:0]            harm_waddr, harm_raddr;
   logic [amd_pkg::SAMPLE_W-1:0]  harm_wdata, harm_rd;

   assign req_ch.ready = ctrl.ready;
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && ctrl.ready;

   assign eff_count = (spk_count_ff > amd_pkg::COUNT_W'(COUNT_LIMIT)) ?
                      amd_pkg::COUNT_W'(COUNT_LIMIT) : spk_count_ff;
   assign eff_order = (MAX_ORDER < 7 && order_ff > amd_pkg::ORDER_W'(MAX_ORDER)) ?
                      amd_pkg::ORDER_W'(MAX_ORDER) : order_ff;
   assign comp_end  = {eff_order, 1'b0};

   assign decode_go = req_fire && req_ch.opcode == amd_pkg::OP_PROCESS &&
                      eff_count != '0;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign emit_fire = ctrl.emit && slot_free;
   assign spk_last  = ({1'b0, spk_ff} + 5'd1) == eff_count;

   assign wr_coef_ok = req_fire && req_ch.opcode == amd_pkg::OP_WRITE_COEF &&
                       int'(req_ch.speaker) < MAX_SPEAKERS &&
                       int'(req_ch.component) < COMPONENTS;
   assign wr_harm_ok = req_fire && req_ch.opcode == amd_pkg::OP_RECORD &&
                       int'(req_ch.component) < COMPONENTS;

   // The clearing pass owns both write ports right after reset.
   always_comb begin
      if (ctrl.clear) begin
         coef_we    = 1'b1;
         coef_waddr = clr_cnt_ff;
         coef_wdata = '0;
         harm_we    = int'(clr_cnt_ff) < COMPONENTS;
         harm_waddr = HADDR_W'(clr_cnt_ff);
         harm_wdata = '0;
      end else begin
         coef_we    = wr_coef_ok;
         coef_waddr = CADDR_W'(int'(req_ch.speaker) * COMPONENTS + int'(req_ch.component));
         coef_wdata = req_ch.coefficient;
         harm_we    = wr_harm_ok;
         harm_waddr = HADDR_W'(req_ch.component);
         harm_wdata = req_ch.harmonic_value;
      end
   end

   assign coef_raddr = CADDR_W'(int'(spk_ff) * COMPONENTS + int'(comp_ff));
   assign harm_raddr = HADDR_W'(comp_ff);

   amd_ram #(
      .WIDTH(amd_pkg::COEF_W),
      .DEPTH(CDEPTH)
   ) u_coef_ram (
      .clock  (clock),
      .wr_en  (coef_we),
      .wr_addr(coef_waddr),
      .wr_data(coef_wdata),
      .rd_addr(coef_raddr),
      .rd_data(coef_rd)
   );

   amd_ram #(
      .WIDTH(amd_pkg::SAMPLE_W),
      .DEPTH(COMPONENTS)
   ) u_harm_ram (
      .clock  (clock),
      .wr_en  (harm_we),
      .wr_addr(harm_waddr),
      .wr_data(harm_wdata),
      .rd_addr(harm_raddr),
      .rd_data(harm_rd)
   );

   // Floor shift by the fraction width, then clamp when the bits above the
   // sample's sign do not all agree with it.
   always_comb begin
      sat_bits = acc_ff[amd_pkg::ACC_W-1:SAT_LSB];
      if ((&sat_bits) || !(|sat_bits)) begin
         sample = acc_ff[SAT_LSB:amd_pkg::FRAC_BITS];
      end else if (acc_ff[amd_pkg::ACC_W-1]) begin
         sample = amd_pkg::SAMPLE_MIN;
      end else begin
         sample = amd_pkg::SAMPLE_MAX;
      end
   end

   always_comb begin
      spk_count_in = spk_count_ff;
      order_in     = order_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            amd_pkg::REG_SPEAKER_COUNT: spk_count_in = csr_ch.data;
            amd_pkg::REG_DECODE_ORDER:  order_in = csr_ch.data[amd_pkg::ORDER_W-1:0];
            default: ;
         endcase
      end

      clr_cnt_in = ctrl.clear ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

      spk_in  = spk_ff;
      comp_in = comp_ff;
      if (decode_go) begin
         spk_in  = '0;
         comp_in = '0;
      end else if (emit_fire) begin
         spk_in  = spk_ff + 1'b1;
         comp_in = '0;
      end else if (ctrl.issue) begin
         comp_in = comp_ff + 1'b1;
      end

      // RAM data lands in the RAM's read register, then the product in prod_ff.
      data_v_in = ctrl.issue;
      prod_v_in = data_v_ff;
      prod_in   = data_v_ff ? amd_pkg::PROD_W'($signed(coef_rd)) *
                              amd_pkg::PROD_W'($signed(harm_rd)) : prod_ff;

      if (decode_go || emit_fire) begin
         acc_in = '0;
      end else if (prod_v_ff) begin
         acc_in = acc_ff + amd_pkg::ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end

      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_index_in  = spk_ff;
         rsp_sample_in = sample;
         rsp_last_in   = spk_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spk_count_ff <= amd_pkg::SPEAKER_COUNT_RST;
         order_ff     <= amd_pkg::DECODE_ORDER_RST;
         clr_cnt_ff   <= '0;
         spk_ff       <= '0;
         comp_ff      <= '0;
         data_v_ff    <= 1'b0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         spk_count_ff <= spk_count_in;
         order_ff     <= order_in;
         clr_cnt_ff   <= clr_cnt_in;
         spk_ff       <= spk_in;
         comp_ff      <= comp_in;
         data_v_ff    <= data_v_in;
         prod_v_ff    <= prod_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.speaker_index  = rsp_index_ff;
   assign rsp_ch.speaker_sample = rsp_sample_ff;
   assign rsp_ch.last           = rsp_last_ff;

   assign status.clear_done = clr_cnt_ff == CADDR_W'(CDEPTH - 1);
   assign status.decode_go  = decode_go;
   assign status.comp_last  = comp_ff == comp_end;
   assign status.spk_last   = spk_last;
   assign status.slot_free  = slot_free;

endmodule

`default_nettype wire

[design/ambisonic_matrix_decoder.sv]
// Coefficient writes and harmonic records are taken back to back.
// A decode of N speakers over K = 2*order+1 components holds the input off
// until the last speaker's result is emitted; each speaker is K reads through
// the one shared multiplier plus a drain through WAIT1, WAIT2 and EMIT, and a
// result that waits in the output register holds the sequencer.
// Reset clears both stores, one entry a cycle, MAX_SPEAKERS*(2*MAX_ORDER+1) entries.
`default_nettype none

module ambisonic_matrix_decoder #(
   parameter int MAX_SPEAKERS = amd_pkg::MAX_SPEAKERS_DEF,
   parameter int MAX_ORDER    = amd_pkg::MAX_ORDER_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   amd_req_if.sink   req_ch,
   amd_rsp_if.source rsp_ch,
   amd_csr_if.sink   csr_ch
);

   amd_pkg::amd_ctrl_type   ctrl;
   amd_pkg::amd_status_type status;

   amd_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .status(status),
      .ctrl  (ctrl)
   );

   amd_datapath #(
      .MAX_SPEAKERS(MAX_SPEAKERS),
      .MAX_ORDER   (MAX_ORDER)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .status(status),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

endmodule

`default_nettype wire
